// ===== src/mpct_pkg.sv =====
// package for the mouse packet cursor tracker
// widths, reset values, status bit positions and register indexes
// no dependencies
`default_nettype none

package mpct_pkg;

   localparam int POS_BITS   = 12;
   localparam int CFG_BITS   = 12;
   localparam int BYTE_BITS  = 8;
   localparam int DELTA_BITS = BYTE_BITS + 1;
   localparam int STEP_BITS  = DELTA_BITS + 1;
   localparam int NEXT_BITS  = ((POS_BITS > CFG_BITS) ? POS_BITS : CFG_BITS) + 2;
   localparam int CSR_IDX_BITS = 1;

   localparam logic [POS_BITS-1:0] POS_RESET = POS_BITS'(500);
   localparam logic [CFG_BITS-1:0] WIDTH_RESET  = CFG_BITS'(1024);
   localparam logic [CFG_BITS-1:0] HEIGHT_RESET = CFG_BITS'(768);

   localparam int BIT_SYNC  = 3;
   localparam int BIT_XSIGN = 4;
   localparam int BIT_YSIGN = 5;
   localparam int BIT_XOVF  = 6;
   localparam int BIT_YOVF  = 7;

   localparam logic signed [DELTA_BITS-1:0] DELTA_OVF_POS = DELTA_BITS'(255);
   localparam logic signed [DELTA_BITS-1:0] DELTA_OVF_NEG = -DELTA_BITS'(255);

   localparam logic [CSR_IDX_BITS-1:0] CSR_SCREEN_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SCREEN_HEIGHT = 1'b1;

   typedef logic [POS_BITS-1:0]         pos_type;
   typedef logic [CFG_BITS-1:0]         cfg_type;
   typedef logic [BYTE_BITS-1:0]        byte_type;
   typedef logic signed [DELTA_BITS-1:0] delta_type;
   typedef logic signed [STEP_BITS-1:0]  step_type;
   typedef logic [CSR_IDX_BITS-1:0]     csr_idx_type;

endpackage

`default_nettype wire

// ===== src/mpct_if.sv =====
// channel interfaces of the mouse packet cursor tracker
// depends on mpct_pkg
`default_nettype none

interface mpct_req_if;
   import mpct_pkg::*;
   logic     valid;
   logic     ready;
   byte_type rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mpct_rsp_if;
   import mpct_pkg::*;
   logic      valid;
   logic      ready;
   pos_type   cursor_x;
   pos_type   cursor_y;
   delta_type delta_x;
   delta_type delta_y;
   modport source (output valid, output cursor_x, output cursor_y,
                   output delta_x, output delta_y, input ready);
   modport sink   (input valid, input cursor_x, input cursor_y,
                   input delta_x, input delta_y, output ready);
endinterface

interface mpct_csr_if;
   import mpct_pkg::*;
   logic        valid;
   logic        ready;
   csr_idx_type index;
   cfg_type     data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/mpct_axis.sv =====
// one cursor axis: applies a signed step, keeps it strictly inside (0, limit)
// depends on mpct_pkg
`default_nettype none

module mpct_axis (
   input  mpct_pkg::pos_type  pos,
   input  mpct_pkg::step_type step,
   input  mpct_pkg::cfg_type  limit,
   output mpct_pkg::pos_type  new_pos
);
   import mpct_pkg::*;

   logic signed [NEXT_BITS-1:0] next_sum;
   logic signed [NEXT_BITS-1:0] limit_ext;
   logic                        hold;

   always_comb begin
      next_sum  = NEXT_BITS'(signed'({1'b0, pos})) + NEXT_BITS'(step);
      limit_ext = NEXT_BITS'(signed'({1'b0, limit}));
      hold      = (next_sum <= NEXT_BITS'(0)) || (next_sum >= limit_ext);
      new_pos   = hold ? pos : next_sum[POS_BITS-1:0];
   end

endmodule

`default_nettype wire

// ===== src/mouse_packet_cursor_tracker_unit.sv =====
// mouse packet cursor tracker: assembles three-byte mouse packets, tracks cursor
// depends on mpct_pkg, mpct_if, mpct_axis
//
// usage
//   req_chan: one received mouse byte per transfer (rx_byte)
//   rsp_chan: one transfer per completed packet: cursor_x, cursor_y, delta_x,
//             delta_y; status and x bytes give no transfer, nor does a status
//             byte with bit 3 clear (it is dropped to resync the stream)
//   csr_chan: index 0 horizontal screen size, index 1 vertical screen size;
//             always ready, write only while no byte is in flight
// ordering: a byte is registered in the input register on acceptance and decoded from
//   there; a third packet byte loads the result register, which drives the rsp transfer
// throughput: one byte per cycle; the input register and the result register
//   make a two-stage path, so req_chan only stalls when a finished packet
//   waits in the result register and the byte in the input register also
//   completes a packet
// reset: expects a status byte, cursor at (500, 500), screen 1024 x 768,
//   both channels empty
// receiver stall: the result is held in place; status and x bytes keep flowing
`default_nettype none

module mouse_packet_cursor_tracker_unit (
   input wire logic   clock,
   input wire logic   reset,
   mpct_req_if.sink   req_chan,
   mpct_rsp_if.source rsp_chan,
   mpct_csr_if.sink   csr_chan
);
   import mpct_pkg::*;

   typedef enum logic [1:0] {
      POS_STATUS = 2'd0,
      POS_XMOVE  = 2'd1,
      POS_YMOVE  = 2'd2
   } byte_pos_type;

   function automatic delta_type decode_delta(byte_type mv, logic sgn, logic ovf);
      delta_type d;
      if (ovf) begin
         d = sgn ? DELTA_OVF_NEG : DELTA_OVF_POS;
      end else begin
         d = signed'({sgn, mv});
      end
      return d;
   endfunction

   logic         in_valid_ff, in_valid_in;
   byte_type     in_byte_ff, in_byte_in;
   byte_pos_type bpos_ff, bpos_in;
   byte_type     status_ff, status_in;
   byte_type     xmove_ff, xmove_in;
   pos_type      pos_x_ff, pos_x_in;
   pos_type      pos_y_ff, pos_y_in;
   cfg_type      width_ff, width_in;
   cfg_type      height_ff, height_in;
   logic         rsp_valid_ff, rsp_valid_in;
   pos_type      cur_x_ff, cur_x_in;
   pos_type      cur_y_ff, cur_y_in;
   delta_type    dx_ff, dx_in;
   delta_type    dy_ff, dy_in;

   logic      completes;
   logic      advance;
   logic      req_take;
   delta_type dx;
   delta_type dy;
   step_type  step_x;
   step_type  step_y;
   pos_type   moved_x;
   pos_type   moved_y;

   always_comb begin
      dx     = decode_delta(xmove_ff, status_ff[BIT_XSIGN], status_ff[BIT_XOVF]);
      dy     = decode_delta(in_byte_ff, status_ff[BIT_YSIGN], status_ff[BIT_YOVF]);
      step_x = STEP_BITS'(dx);
      step_y = -STEP_BITS'(dy);
   end

   mpct_axis u_axis_x (
      .pos     (pos_x_ff),
      .step    (step_x),
      .limit   (width_ff),
      .new_pos (moved_x)
   );

   mpct_axis u_axis_y (
      .pos     (pos_y_ff),
      .step    (step_y),
      .limit   (height_ff),
      .new_pos (moved_y)
   );

   assign completes      = in_valid_ff && (bpos_ff == POS_YMOVE);
   assign advance        = in_valid_ff && (!completes || !rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   always_comb begin
      in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      in_byte_in   = req_take ? req_chan.rx_byte : in_byte_ff;
      bpos_in      = bpos_ff;
      status_in    = status_ff;
      xmove_in     = xmove_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;

      if (advance) begin
         unique case (bpos_ff)
            POS_XMOVE: begin
               xmove_in = in_byte_ff;
               bpos_in  = POS_YMOVE;
            end
            POS_YMOVE: begin
               bpos_in      = POS_STATUS;
               pos_x_in     = moved_x;
               pos_y_in     = moved_y;
               rsp_valid_in = 1'b1;
               cur_x_in     = moved_x;
               cur_y_in     = moved_y;
               dx_in        = dx;
               dy_in        = dy;
            end
            default: begin
               bpos_in = POS_STATUS;
               if (in_byte_ff[BIT_SYNC]) begin
                  status_in = in_byte_ff;
                  bpos_in   = POS_XMOVE;
               end
            end
         endcase
      end

      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_SCREEN_WIDTH:  width_in  = csr_chan.data;
            CSR_SCREEN_HEIGHT: height_in = csr_chan.data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         bpos_ff      <= POS_STATUS;
         status_ff    <= '0;
         xmove_ff     <= '0;
         pos_x_ff     <= POS_RESET;
         pos_y_ff     <= POS_RESET;
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         bpos_ff      <= bpos_in;
         status_ff    <= status_in;
         xmove_ff     <= xmove_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_byte_ff <= in_byte_in;
      cur_x_ff   <= cur_x_in;
      cur_y_ff   <= cur_y_in;
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.cursor_x = cur_x_ff;
   assign rsp_chan.cursor_y = cur_y_ff;
   assign rsp_chan.delta_x  = dx_ff;
   assign rsp_chan.delta_y  = dy_ff;

   // a result is only loaded from the third byte of a packet
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(bpos_ff) == POS_YMOVE))
      else $error("result loaded outside the third packet byte");

   // a moved x coordinate lands strictly inside the screen
   assert property (@(posedge clock) disable iff (reset)
      (pos_x_ff != $past(pos_x_ff)) |->
         ((pos_x_ff != '0) && (POS_BITS'(pos_x_ff) < POS_BITS'(width_ff))
          || (NEXT_BITS'(pos_x_ff) < NEXT_BITS'(width_ff)) && (pos_x_ff != '0)))
      else $error("cursor x moved out of bounds");

   // input stalls only behind a held result while a packet completes
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !req_chan.ready) |->
         (rsp_valid_ff && !rsp_chan.ready && (bpos_ff == POS_YMOVE)))
      else $error("input stalled without a blocked result");

endmodule

`default_nettype wire
